/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the keyword matcher.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of aclk outside of reset.
`define SCKM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property checked on every rising edge of aclk, reset cycles included.
`define SCKM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* rtl/sckm_pkg.sv */
// Package for the serial command keyword matcher: character codes,
// keyword tables and the default store depth. No dependencies.
`default_nettype none

package sckm_pkg;

    localparam int unsigned STORE_DEPTH_DEF = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int unsigned KW_START_LEN = 5;
    localparam int unsigned KW_STOP_LEN  = 4;

    localparam logic [7:0] KW_START [KW_START_LEN] = '{8'h73, 8'h74, 8'h61, 8'h72, 8'h74};
    localparam logic [7:0] KW_STOP  [KW_STOP_LEN]  = '{8'h73, 8'h74, 8'h6F, 8'h70};

endpackage

`default_nettype wire

/* rtl/serial_command_keyword_matcher.sv */
// Top level of the serial command keyword matcher: byte store, keyword
// compare and output register. Depends on sckm_pkg and assert_macros.svh.
//
//   Channel   Ports                                   Direction   Word
//   input     s_valid, s_ready, s_rx_byte             in          one received byte
//   result    m_valid, m_ready, m_start_seen,         out         two match flags
//             m_stop_seen
//
// Every accepted byte yields exactly one result word in the cycle after acceptance.
// The store update and both keyword compares run in the cycle the byte is taken,
// so one byte per cycle is sustained unless the result side stalls; the output
// register is the only stage. s_ready is high whenever that register is empty or
// is being drained, so a stall on the result side holds back at most one word.
// Reset (aresetn low at a clock edge) zeroes the store and the write index and
// empties the output register; no clearing pass is needed afterwards.
`default_nettype none

module serial_command_keyword_matcher
    import sckm_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_start_seen,
    output logic            m_stop_seen
);

    // The index addresses STORE_DEPTH entries; the incremented count needs one
    // bit more so that it can reach STORE_DEPTH itself.
    localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(STORE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STORE_DEPTH);

    logic [7:0]       char_store_reg  [STORE_DEPTH];
    logic [7:0]       char_store_next [STORE_DEPTH];
    logic [7:0]       store_wr        [STORE_DEPTH];
    logic [IDX_W-1:0] write_index_reg;
    logic [IDX_W-1:0] write_index_next;
    logic [CNT_W-1:0] idx_inc;

    logic             m_valid_reg;
    logic             start_seen_reg;
    logic             stop_seen_reg;
    logic             start_next;
    logic             stop_next;
    logic             start_hit;
    logic             stop_hit;
    logic             in_accept;

    // The input side runs whenever the output register has room this cycle.
    assign s_ready      = !m_valid_reg || m_ready;
    assign in_accept    = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_start_seen = start_seen_reg;
    assign m_stop_seen  = stop_seen_reg;

    // Store as it would look with the incoming byte written at the index.
    // The keyword compares read fixed entries of this view: the keyword's
    // characters are nonzero, so a match also implies no earlier terminator,
    // and the entry right after the keyword must be the terminator.
    always_comb begin
        store_wr = char_store_reg;
        store_wr[write_index_reg] = s_rx_byte;
        idx_inc = {1'b0, write_index_reg} + CNT_W'(1);

        start_hit = (store_wr[KW_START_LEN] == CH_NUL);
        for (int i = 0; i < KW_START_LEN; i++) begin
            if (store_wr[i] != KW_START[i]) begin
                start_hit = 1'b0;
            end
        end

        stop_hit = (store_wr[KW_STOP_LEN] == CH_NUL);
        for (int i = 0; i < KW_STOP_LEN; i++) begin
            if (store_wr[i] != KW_STOP[i]) begin
                stop_hit = 1'b0;
            end
        end
    end

    // Next store contents, index and flags for the byte on the input.
    always_comb begin
        char_store_next  = char_store_reg;
        write_index_next = write_index_reg;
        start_next       = 1'b0;
        stop_next        = 1'b0;

        case (s_rx_byte)
            CH_SPACE: begin
                // A space wipes what was typed so far and restarts the word.
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    if (IDX_W'(i) < write_index_reg) begin
                        char_store_next[i] = CH_NUL;
                    end
                end
                write_index_next = '0;
            end
            CH_CR: begin
                // Carriage returns are dropped without effect.
            end
            CH_LF: begin
                // A line feed restarts the index but leaves old bytes behind.
                write_index_next = '0;
            end
            default: begin
                char_store_next = store_wr;
                if (start_hit || stop_hit) begin
                    start_next = start_hit;
                    stop_next  = !start_hit;
                    for (int i = 0; i < STORE_DEPTH; i++) begin
                        if (CNT_W'(i) < idx_inc) begin
                            char_store_next[i] = CH_NUL;
                        end
                    end
                    write_index_next = '0;
                end else if (idx_inc == CNT_FULL) begin
                    // The store filled up without a keyword: start over clean.
                    for (int i = 0; i < STORE_DEPTH; i++) begin
                        char_store_next[i] = CH_NUL;
                    end
                    write_index_next = '0;
                end else begin
                    write_index_next = idx_inc[IDX_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                char_store_reg[i] <= CH_NUL;
            end
            write_index_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (in_accept) begin
                char_store_reg  <= char_store_next;
                write_index_reg <= write_index_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    // Result flags are payload and need no reset.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            start_seen_reg <= start_next;
            stop_seen_reg  <= stop_next;
        end
    end

    `include "assert_macros.svh"

    `SCKM_ASSERT(a_one_keyword, m_valid |-> !(m_start_seen && m_stop_seen), "both keyword flags set")
    `SCKM_ASSERT(a_index_range, write_index_reg <= IDX_MAX, "write index out of range")
    `SCKM_ASSERT(a_match_restarts, (in_accept && (start_next || stop_next)) |=> (write_index_reg == '0), "index not reset after keyword")
    `SCKM_ASSERT(a_result_follows, in_accept |=> m_valid, "accepted byte produced no result word")

endmodule

`default_nettype wire
